[src/lbps_pkg.sv]
// ----------------------------------------------------------------------------
// lbps_pkg: shared types and constants for the light bar pair selector
// Holds field widths, register indexes, the CORDIC arctangent table and
// the sequencer state type.
// ----------------------------------------------------------------------------
package lbps_pkg;

    localparam int MaxBars     = 32;
    localparam int IdxW        = $clog2(MaxBars);
    localparam int CntW        = $clog2(MaxBars + 1);
    localparam int CordicSteps = 15;
    localparam int StepW       = 4;
    localparam int AngleW      = 15;
    localparam int AngleMax    = 25736;
    localparam int CordW       = 32;   // h,w * 2^16 plus growth, signed

    localparam logic [1:0] RegAngleThr = 2'd0;
    localparam logic [1:0] RegMinH     = 2'd1;
    localparam logic [1:0] RegMinW     = 2'd2;
    localparam logic [1:0] RegAspect   = 2'd3;

    typedef struct packed {
        logic [11:0]       x;
        logic [11:0]       y;
        logic [11:0]       w;
        logic [11:0]       h;
        logic [AngleW-1:0] ang;
    } t_bar;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORDIC,
        S_RD_A,
        S_RD_B,
        S_CMP,
        S_OUT
    } t_state;

    function automatic logic [13:0] atan_tab(input logic [StepW-1:0] i);
        case (i)
            4'd0:    atan_tab = 14'd12868;
            4'd1:    atan_tab = 14'd7596;
            4'd2:    atan_tab = 14'd4014;
            4'd3:    atan_tab = 14'd2037;
            4'd4:    atan_tab = 14'd1023;
            4'd5:    atan_tab = 14'd512;
            4'd6:    atan_tab = 14'd256;
            4'd7:    atan_tab = 14'd128;
            4'd8:    atan_tab = 14'd64;
            4'd9:    atan_tab = 14'd32;
            4'd10:   atan_tab = 14'd16;
            4'd11:   atan_tab = 14'd8;
            4'd12:   atan_tab = 14'd4;
            4'd13:   atan_tab = 14'd2;
            4'd14:   atan_tab = 14'd1;
            default: atan_tab = 14'd0;
        endcase
    endfunction

endpackage

[src/lbps_cordic.sv]
// ----------------------------------------------------------------------------
// lbps_cordic: iterative CORDIC vectoring unit
// One micro-rotation per cycle; angle of (w, h) in 2^-14 rad, clamped.
// ----------------------------------------------------------------------------
module lbps_cordic (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [11:0]                      i_w,
    input  logic [11:0]                      i_h,
    output logic                             o_done,
    output logic [lbps_pkg::AngleW-1:0]      o_angle
);
    logic signed [lbps_pkg::CordW-1:0] r_x, r_y, n_x, n_y;
    logic signed [16:0]                r_z, n_z;
    logic [lbps_pkg::StepW-1:0]        r_i;
    logic                              r_busy, r_done;
    logic signed [lbps_pkg::CordW-1:0] dx, dy;
    logic signed [16:0]                t;

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign t  = signed'({3'b000, lbps_pkg::atan_tab(r_i)});

    always_comb begin
        if (r_y >= 0) begin
            n_x = r_x + dx; n_y = r_y - dy; n_z = r_z + t;
        end else begin
            n_x = r_x - dx; n_y = r_y + dy; n_z = r_z - t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= signed'({4'd0, i_w, 16'd0});
                r_y    <= signed'({4'd0, i_h, 16'd0});
                r_z    <= '0;
            end else if (r_busy) begin
                r_x <= n_x; r_y <= n_y; r_z <= n_z;
                r_i <= r_i + 1'b1;
                if (r_i == lbps_pkg::StepW'(lbps_pkg::CordicSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = (r_z < 0) ? '0 :
                     (r_z > 17'sd25736) ? lbps_pkg::AngleW'(lbps_pkg::AngleMax) :
                     r_z[lbps_pkg::AngleW-1:0];
endmodule

[src/light_bar_pair_selector.sv]
// ----------------------------------------------------------------------------
// light_bar_pair_selector: picks the best matching pair of light bars
// Filters rectangles, stores them with their angle, and at frame end
// searches all pairs for the smallest area difference under an angle limit.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream s_axis: one rectangle per word, tlast marks frame end.
//  - Output stream m_axis: one word per frame, sent after the last word.
//  - APB port sets angle threshold, min height, min width, aspect tenths.
//  - A kept rectangle runs the 15-step CORDIC loop plus handoff before the
//    next word is taken; a rejected one skips it. Ready is low while an item is in work.
//  - At frame end the pair search walks pairs i<j through the bar memory,
//    one pair at a time (two registered reads, one compare), for N >= 2
//    stored bars, and then passes through the output state.
//  - The output register holds the result while the receiver stalls; the
//    next frame's words are still taken, and its result waits in the
//    output state (ready low) until the register is free.
//  - Reset (synchronous, active low) restores register defaults and
//    clears the bar count, overflow flag and output valid. No clearing
//    pass: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module light_bar_pair_selector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] rect_x, [23:12] rect_y, [35:24] rect_width, [47:36] rect_height
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] pair_found, [1] overflowed, [14:2] first_center_x, [26:15] first_top_y,
    // [39:27] first_bottom_y, [52:40] second_center_x, [64:53] second_top_y,
    // [77:65] second_bottom_y, [79:78] zero
    output logic [79:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = lbps_pkg::IdxW;
    localparam int CW = lbps_pkg::CntW;

    // configuration registers
    logic [14:0] r_thr;
    logic [11:0] r_min_h, r_min_w;
    logic [7:0]  r_aspect;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= 15'd5147;
            r_min_h  <= 12'd36;
            r_min_w  <= 12'd20;
            r_aspect <= 8'd13;
        end else if (wr_en) begin
            case (reg_idx)
                lbps_pkg::RegAngleThr: r_thr    <= pwdata[14:0];
                lbps_pkg::RegMinH:     r_min_h  <= pwdata[11:0];
                lbps_pkg::RegMinW:     r_min_w  <= pwdata[11:0];
                lbps_pkg::RegAspect:   r_aspect <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lbps_pkg::RegAngleThr: prdata = {17'd0, r_thr};
            lbps_pkg::RegMinH:     prdata = {20'd0, r_min_h};
            lbps_pkg::RegMinW:     prdata = {20'd0, r_min_w};
            lbps_pkg::RegAspect:   prdata = {24'd0, r_aspect};
            default:               prdata = '0;
        endcase
    end

    // input word fields
    logic [11:0] in_x, in_y, in_w, in_h;
    assign in_x = s_axis_tdata[11:0];
    assign in_y = s_axis_tdata[23:12];
    assign in_w = s_axis_tdata[35:24];
    assign in_h = s_axis_tdata[47:36];

    logic [15:0] h10;
    logic [19:0] w_asp;
    logic        keep;
    assign h10   = 16'(in_h) * 16'd10;
    assign w_asp = 20'(in_w) * 20'(r_aspect);
    assign keep  = (in_h > r_min_h) && (in_w > r_min_w) && (20'(h10) >= w_asp);

    lbps_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic          r_ovf, r_last;
    logic [11:0]   r_x, r_y, r_w, r_h;
    logic [IW-1:0] r_i, r_j;
    logic          r_found;
    logic [23:0]   r_best;
    logic          in_acc, out_acc, out_free;

    assign s_axis_tready = (r_state == lbps_pkg::S_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;

    // CORDIC unit
    logic                      cord_start, cord_done;
    logic [lbps_pkg::AngleW-1:0] cord_ang;
    assign cord_start = in_acc && keep && (r_cnt < CW'(lbps_pkg::MaxBars));

    lbps_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_w     (in_w),
        .i_h     (in_h),
        .o_done  (cord_done),
        .o_angle (cord_ang)
    );

    // bar memory, one write and one registered read port
    lbps_pkg::t_bar mem [lbps_pkg::MaxBars];
    lbps_pkg::t_bar r_rd, r_a, r_fa, r_fb;
    logic [IW-1:0]  rd_addr;
    logic           mem_we;

    assign mem_we = (r_state == lbps_pkg::S_CORDIC) && cord_done;

    always_ff @(posedge i_clk) begin
        if (mem_we)
            mem[r_cnt[IW-1:0]] <= '{x: r_x, y: r_y, w: r_w, h: r_h, ang: cord_ang};
        r_rd <= mem[rd_addr];
    end

    // RD_A reads bar i, RD_B latches it and reads bar j, CMP scores the pair
    assign rd_addr = (r_state == lbps_pkg::S_RD_B) ? r_j : r_i;

    // pair scoring: r_a holds bar i, r_rd bar j
    logic [14:0] adiff;
    logic [23:0] area_a, area_b, score;
    logic        pass, better, last_j, last_i;
    assign adiff  = (r_a.ang > r_rd.ang) ? r_a.ang - r_rd.ang : r_rd.ang - r_a.ang;
    assign area_a = 24'(r_a.w) * 24'(r_a.h);
    assign area_b = 24'(r_rd.w) * 24'(r_rd.h);
    assign score  = (area_a > area_b) ? area_a - area_b : area_b - area_a;
    assign pass   = adiff < r_thr;
    assign better = pass && (!r_found || score < r_best);
    assign last_j = (CW'(r_j) + 1'b1) >= r_cnt;
    assign last_i = (CW'(r_i) + 2'd2) >= r_cnt;

    logic start_search;
    assign start_search = r_cnt >= CW'(2);

    always_comb begin
        n_state = r_state;
        case (r_state)
            lbps_pkg::S_IDLE:
                if (in_acc) begin
                    if (cord_start)        n_state = lbps_pkg::S_CORDIC;
                    else if (s_axis_tlast) n_state = start_search ?
                                                     lbps_pkg::S_RD_A : lbps_pkg::S_OUT;
                end
            lbps_pkg::S_CORDIC:
                // the bar written now makes at least two when one was stored
                if (cord_done) begin
                    if (!r_last)              n_state = lbps_pkg::S_IDLE;
                    else if (r_cnt != '0)     n_state = lbps_pkg::S_RD_A;
                    else                      n_state = lbps_pkg::S_OUT;
                end
            lbps_pkg::S_RD_A: n_state = lbps_pkg::S_RD_B;
            lbps_pkg::S_RD_B: n_state = lbps_pkg::S_CMP;
            lbps_pkg::S_CMP:
                if (last_j && last_i) n_state = lbps_pkg::S_OUT;
                else                  n_state = lbps_pkg::S_RD_A;
            lbps_pkg::S_OUT:
                if (out_free) n_state = lbps_pkg::S_IDLE;
            default:          n_state = lbps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lbps_pkg::S_IDLE;
            r_cnt         <= '0;
            r_ovf         <= 1'b0;
            r_found       <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_x <= in_x; r_y <= in_y; r_w <= in_w; r_h <= in_h;
                r_last <= s_axis_tlast;
                r_i <= '0; r_j <= IW'(1);
                r_found <= 1'b0;
                if (keep && !cord_start) r_ovf <= 1'b1;
            end
            if (mem_we) r_cnt <= r_cnt + 1'b1;
            if (r_state == lbps_pkg::S_RD_B) r_a <= r_rd;
            if (r_state == lbps_pkg::S_CMP) begin
                if (better) begin
                    r_found <= 1'b1;
                    r_best  <= score;
                    r_fa    <= r_a;
                    r_fb    <= r_rd;
                end
                if (last_j) begin
                    r_i <= r_i + 1'b1;
                    r_j <= r_i + IW'(2);
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            // load the output register once the previous word has left
            if (r_state == lbps_pkg::S_OUT && out_free) begin
                m_axis_tvalid <= 1'b1;
                m_axis_tdata  <= {2'b00,
                    r_found ? {13'(r_fb.y) + 13'(r_fb.h), r_fb.y,
                               13'(r_fb.x) + 13'(r_fb.w[11:1])} : 38'd0,
                    r_found ? {13'(r_fa.y) + 13'(r_fa.h), r_fa.y,
                               13'(r_fa.x) + 13'(r_fa.w[11:1])} : 38'd0,
                    r_ovf, r_found};
                r_cnt   <= '0;
                r_ovf   <= 1'b0;
                r_found <= 1'b0;
            end else if (out_acc) begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lbps_pkg::S_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(lbps_pkg::MaxBars))
        else $error("bar count overflow");
    a_out_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == lbps_pkg::S_OUT))
        else $error("result without search");
endmodule

[bench/light_bar_pair_selector_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// light_bar_pair_selector_tb: self-checking bench for the light bar pair selector
// Streams frames of bounding rectangles with random idling on both sides,
// predicts each frame's pair result with a local CORDIC and pair search,
// and checks every output word field by field. APB writes change the
// filter registers between frames.
// ----------------------------------------------------------------------------
module light_bar_pair_selector_tb;

    localparam int WatchdogLimit = 20000;
    localparam int Depth         = 32;
    localparam int TailItems     = 80;

    typedef struct packed {
        logic        last;
        logic [11:0] h;
        logic [11:0] w;
        logic [11:0] y;
        logic [11:0] x;
    } t_rect;

    typedef struct packed {
        logic [12:0] sbot;
        logic [11:0] stop;
        logic [12:0] scx;
        logic [12:0] fbot;
        logic [11:0] ftop;
        logic [12:0] fcx;
        logic        ovf;
        logic        found;
    } t_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    light_bar_pair_selector dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [14:0]    thr_q = 15'd5147;
    logic [11:0]    minh_q = 12'd36;
    logic [11:0]    minw_q = 12'd20;
    logic [7:0]     asp_q = 8'd13;
    lbps_pkg::t_bar bars[Depth];
    int             nbars = 0;
    bit             ovf_q = 0;

    t_rect rect_q[$];     // words waiting for the driver
    t_pair pair_q[$];     // expected result words
    int    errors = 0;
    int    frames_seen = 0;
    int    found_seen = 0;
    bit    quiet = 0;     // no idling in the closing stretch
    bit    done = 0;
    bit    s_acc = 0;     // word on the bus was taken at the last rising edge
    int    stall_s = 0, stall_m = 0, idle_cnt = 0;

    function automatic logic [14:0] cordic_angle(input logic [11:0] w, input logic [11:0] h);
        longint cx, cy, dx, dy;
        int z;
        int tab[15] = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128, 64, 32,
                        16, 8, 4, 2, 1};
        cx = longint'(w) * 65536;
        cy = longint'(h) * 65536;
        z = 0;
        for (int i = 0; i < 15; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx; cy -= dy; z += tab[i];
            end else begin
                cx -= dx; cy += dy; z -= tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > lbps_pkg::AngleMax) z = lbps_pkg::AngleMax;
        return z[14:0];
    endfunction

    // Runs one rectangle through the filter; returns 1 with a result on frame end.
    function automatic bit predict_pair(input t_rect r, output t_pair p);
        int bi, bj, sc, best, aa, ab, d;
        bit hit;
        p = '0;
        if (r.h > minh_q && r.w > minw_q && 32'(r.h) * 10 >= 32'(r.w) * 32'(asp_q)) begin
            if (nbars < Depth) begin
                bars[nbars] = '{x: r.x, y: r.y, w: r.w, h: r.h, ang: cordic_angle(r.w, r.h)};
                nbars++;
            end else ovf_q = 1;
        end
        if (!r.last) return 0;
        hit = 0; best = 0; bi = 0; bj = 0;
        for (int i = 0; i + 1 < nbars; i++)
            for (int j = i + 1; j < nbars; j++) begin
                aa = bars[i].ang; ab = bars[j].ang;
                d = aa > ab ? aa - ab : ab - aa;
                if (d >= thr_q) continue;
                aa = bars[i].w * bars[i].h; ab = bars[j].w * bars[j].h;
                sc = aa > ab ? aa - ab : ab - aa;
                if (!hit || sc < best) begin
                    hit = 1; best = sc; bi = i; bj = j;
                end
            end
        p.found = hit;
        p.ovf = ovf_q;
        if (hit) begin
            p.fcx  = 13'(bars[bi].x) + 13'(bars[bi].w >> 1);
            p.ftop = bars[bi].y;
            p.fbot = 13'(bars[bi].y) + 13'(bars[bi].h);
            p.scx  = 13'(bars[bj].x) + 13'(bars[bj].w >> 1);
            p.stop = bars[bj].y;
            p.sbot = 13'(bars[bj].y) + 13'(bars[bj].h);
        end
        nbars = 0;
        ovf_q = 0;
        return 1;
    endfunction

    always @(posedge i_clk) s_acc <= s_axis_tvalid && s_axis_tready;

    // Driver: the word on the bus is predicted at the edge that accepts it.
    always @(negedge i_clk) begin
        if (i_rst_n && !done) begin
            if (s_axis_tvalid && !s_acc) begin
                // hold the current word
            end else if (stall_s > 0) begin
                stall_s <= stall_s - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_s <= $urandom_range(0, 3);
                s_axis_tvalid <= 1'b0;
            end else if (rect_q.size() > 0) begin
                s_axis_tdata  <= rect_q[0][47:0];
                s_axis_tlast  <= rect_q[0].last;
                s_axis_tvalid <= 1'b1;
                rect_q.pop_front();
            end else s_axis_tvalid <= 1'b0;
            // receiver back-pressure
            if (stall_m > 0) begin
                stall_m <= stall_m - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall_m <= $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else m_axis_tready <= 1'b1;
        end
    end

    // Monitor and scoreboard.
    always @(posedge i_clk) begin
        t_pair got, exp_p;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (predict_pair({s_axis_tlast, s_axis_tdata}, exp_p)) pair_q.push_back(exp_p);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[77:0];
                frames_seen++;
                if (pair_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word %h", $time, got);
                end else begin
                    exp_p = pair_q.pop_front();
                    if (exp_p.found) found_seen++;
                    if (got !== exp_p || m_axis_tdata[79:78] !== 2'b00) begin
                        errors++;
                        $display("%0t: mismatch exp found=%0d ovf=%0d %0d/%0d/%0d %0d/%0d/%0d",
                                 $time, exp_p.found, exp_p.ovf, exp_p.fcx, exp_p.ftop,
                                 exp_p.fbot, exp_p.scx, exp_p.stop, exp_p.sbot);
                        $display("%0t:          got found=%0d ovf=%0d %0d/%0d/%0d %0d/%0d/%0d",
                                 $time, got.found, got.ovf, got.fcx, got.ftop,
                                 got.fbot, got.scx, got.stop, got.sbot);
                    end
                end
            end
            // watchdog
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (psel && penable))
                idle_cnt <= 0;
            else if (rect_q.size() > 0 || pair_q.size() > 0 || s_axis_tvalid) begin
                idle_cnt <= idle_cnt + 1;
                if (idle_cnt >= WatchdogLimit) begin
                    $display("%0t: watchdog expired", $time);
                    $display("** light_bar_pair_selector: FAILED **");
                    $finish;
                end
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            lbps_pkg::RegAngleThr: thr_q  = val[14:0];
            lbps_pkg::RegMinH:     minh_q = val[11:0];
            lbps_pkg::RegMinW:     minw_q = val[11:0];
            lbps_pkg::RegAspect:   asp_q  = val[7:0];
            default: ;
        endcase
    endtask

    // Waits for all queued words and results, then for the pair search tail.
    task automatic drain();
        while (rect_q.size() > 0 || s_axis_tvalid || pair_q.size() > 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic t_rect rand_rect(input bit last);
        t_rect r;
        r.x = 12'($urandom); r.y = 12'($urandom);
        case ($urandom_range(0, 5))
            0:       begin r.w = 12'($urandom); r.h = 12'($urandom); end
            1:       begin
                r.w = 12'($urandom_range(0, 30));
                r.h = 12'($urandom_range(0, 60));
            end
            default: begin
                r.w = 12'($urandom_range(21, 60));
                r.h = 12'($urandom_range(32'(r.w) * 13 / 10 + 1, 200));
            end
        endcase
        r.last = last;
        return r;
    endfunction

    task automatic rand_frames(input int n_items, input int max_len);
        int len;
        while (n_items > 0) begin
            len = $urandom_range(1, max_len);
            for (int k = 0; k < len; k++) rect_q.push_back(rand_rect(k == len - 1));
            n_items -= len;
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: frame with a clear pair, lone bar, empty, extremes, overflow
        rect_q.push_back('{1'b0, 12'd100, 12'd30, 12'd10, 12'd10});
        rect_q.push_back('{1'b0, 12'd102, 12'd31, 12'd50, 12'd50});
        rect_q.push_back('{1'b1, 12'd100, 12'd31, 12'd200, 12'd200});
        rect_q.push_back('{1'b1, 12'd100, 12'd30, 12'd10, 12'd10});
        rect_q.push_back('{1'b1, 12'd0, 12'd0, 12'd0, 12'd0});
        rect_q.push_back('{1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
        rect_q.push_back('{1'b0, 12'd21, 12'd37, 12'hFFF, 12'hFFF});
        rect_q.push_back('{1'b1, 12'd300, 12'd40, 12'd0, 12'd0});
        drain();
        apb_write(lbps_pkg::RegAngleThr, 32'd25736);
        apb_write(lbps_pkg::RegMinH, 32'd0);
        apb_write(lbps_pkg::RegMinW, 32'd0);
        apb_write(lbps_pkg::RegAspect, 32'd0);
        for (int k = 0; k < 34; k++)    // one frame past capacity
            rect_q.push_back('{k == 33, 12'(k + 1), 12'(k + 2), 12'(k), 12'(k * 3)});
        drain();

        apb_write(lbps_pkg::RegAngleThr, 32'd5147);
        apb_write(lbps_pkg::RegMinH, 32'd36);
        apb_write(lbps_pkg::RegMinW, 32'd20);
        apb_write(lbps_pkg::RegAspect, 32'd13);
        rand_frames(120, 8);
        drain();
        apb_write(lbps_pkg::RegAngleThr, 32'd0);
        apb_write(lbps_pkg::RegAspect, 32'd255);
        rand_frames(60, 6);
        drain();
        apb_write(lbps_pkg::RegAngleThr, 32'd2000);
        apb_write(lbps_pkg::RegAspect, 32'd0);
        apb_write(lbps_pkg::RegMinH, 32'd4095);
        rand_frames(30, 6);
        drain();
        apb_write(lbps_pkg::RegMinH, 32'd10);
        apb_write(lbps_pkg::RegMinW, 32'd4095);
        rand_frames(30, 6);
        drain();
        apb_write(lbps_pkg::RegMinW, 32'd5);
        apb_write(lbps_pkg::RegAngleThr, 32'd8000);
        rand_frames(100, 10);
        drain();
        quiet = 1;
        rand_frames(TailItems, 8);
        drain();
        done = 1;

        $display("Checked %0d result words (%0d with a pair) over several filter settings,",
                 frames_seen, found_seen);
        $display("including overflowed frames and both-side idling.");
        if (errors == 0)
            $display("** light_bar_pair_selector: PASSED **");
        else
            $display("** light_bar_pair_selector: FAILED **");
        $finish;
    end
endmodule
